[hdl/aio_pkg.sv]
// ----------------------------------------------------------------------------
// aio_pkg
// Types, register addresses and command codes shared by the control I/O
// register block, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package aio_pkg;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   // sample slots
   localparam logic [3:0] SLOT_SYS0     = 4'd0;
   localparam logic [3:0] SLOT_SYS1     = 4'd1;
   localparam logic [3:0] SLOT_LEVER1   = 4'd2;
   localparam logic [3:0] SLOT_LEVER2   = 4'd3;
   localparam logic [3:0] SLOT_GUN_Y1   = 4'd4;
   localparam logic [3:0] SLOT_GUN_X1   = 4'd5;
   localparam logic [3:0] SLOT_GUN_Y2   = 4'd6;
   localparam logic [3:0] SLOT_GUN_X2   = 4'd7;
   localparam logic [3:0] SLOT_ACQUIRED = 4'd8;
   localparam logic [3:0] SLOT_STEER    = 4'd9;
   localparam logic [3:0] SLOT_ACCEL    = 4'd10;
   localparam logic [3:0] SLOT_BRAKE    = 4'd11;

   // register addresses
   localparam logic [5:0] ADDR_BANK      = 6'h00;
   localparam logic [5:0] ADDR_EEPROM    = 6'h04;
   localparam logic [5:0] ADDR_LEVER1    = 6'h08;
   localparam logic [5:0] ADDR_LEVER2    = 6'h0C;
   localparam logic [5:0] ADDR_ZERO_HIGH = 6'h07;
   localparam logic [5:0] ADDR_ZERO_ONE  = 6'h18;
   localparam logic [5:0] ADDR_MCU_CMD   = 6'h24;
   localparam logic [5:0] ADDR_GUN_ADDR  = 6'h28;
   localparam logic [5:0] ADDR_MCU_FLAG  = 6'h2C;
   localparam logic [5:0] ADDR_GUN_DATA  = 6'h30;
   localparam logic [5:0] ADDR_STEER     = 6'h3C;

   // mcu commands
   localparam logic [7:0] CMD_LATCH = 8'h00;
   localparam logic [7:0] CMD_COPY  = 8'h87;

   localparam logic [10:0] GUN_X2_OFFSET = 11'd400;
   localparam logic [7:0]  STEER_OFFSET  = 8'h80;

   localparam int REG_DEPTH   = 64;
   localparam int GUN_DEPTH   = 16;
   localparam int STEER_DEPTH = 8;

   typedef struct packed {
      opcode_type  opcode;
      logic [5:0]  address;
      logic [7:0]  write_data;
      logic [3:0]  sample_slot;
      logic [10:0] sample_value;
      logic        eeprom_data_in;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       eeprom_strobe;
      logic       eeprom_line_b6;
      logic       eeprom_line_b7;
      logic       eeprom_line_b5;
      logic       eeprom_line_b4;
   } rsp_payload_type;

   // value a register holds until it is first written
   function automatic logic [7:0] reg_reset_value(input logic [5:0] addr);
      logic [7:0] val;
      if (addr <= ADDR_ZERO_HIGH || addr == ADDR_ZERO_ONE) begin
         val = 8'h00;
      end else begin
         val = 8'hFF;
      end
      return val;
   endfunction

endpackage

[hdl/aio_if.sv]
// ----------------------------------------------------------------------------
// aio channel interfaces
// Valid/ready channels for requests into and responses out of the control
// I/O register block.
// ----------------------------------------------------------------------------
interface aio_req_if;
   logic                     valid;
   logic                     ready;
   aio_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface aio_rsp_if;
   logic                     valid;
   logic                     ready;
   aio_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hdl/arcade_control_io_registers.sv]
// ----------------------------------------------------------------------------
// arcade_control_io_registers
// Control I/O register file with bank, gun and steering inputs, an eeprom
// line strobe and mcu commands, built around a 64 x 8 synchronous memory.
// ----------------------------------------------------------------------------
// response: registered; a bus read that goes to the register memory is answered
//   from ST_RD after the registered memory read
// throughput: 1 request per cycle when not busy and the response is not stalled;
//   busy: ST_RD (memory read), ST_PTR (mcu 0x00), ST_CLR, ST_GUN (0x87, single write port)
// reset: synchronous; clears control state and the 64 written-flags at once,
//   unwritten registers read their reset value, no clearing pass
module arcade_control_io_registers (
   input logic        clock,
   input logic        reset,
   aio_req_if.sink    req_chan,
   aio_rsp_if.source  rsp_chan
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_RD   = 5'b00010,
      ST_PTR  = 5'b00100,
      ST_CLR  = 5'b01000,
      ST_GUN  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [7:0] reg_mem [aio_pkg::REG_DEPTH];
   logic [aio_pkg::REG_DEPTH-1:0] written_ff, written_in;
   logic [7:0] rd_q_ff;
   logic [5:0] rd_addr, wr_addr;
   logic [7:0] wr_data;
   logic       wr_en;

   logic [5:0] addr_ff, addr_in;
   logic [7:0] bank_ff [2];
   logic [7:0] bank_in [2];
   logic       bank_sel_ff, bank_sel_in;
   logic [7:0] gun_ff [aio_pkg::GUN_DEPTH];
   logic [7:0] gun_in [aio_pkg::GUN_DEPTH];
   logic [3:0] gun_ptr_ff, gun_ptr_in;
   logic [7:0] steer_ff [aio_pkg::STEER_DEPTH];
   logic [7:0] steer_in [aio_pkg::STEER_DEPTH];
   logic [2:0] steer_cnt_ff, steer_cnt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   aio_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   aio_pkg::req_payload_type req;
   logic        accept;
   logic [7:0]  merged_bank1;
   logic [10:0] gun_x2;
   logic [7:0]  gun_addr_reset;

   assign req            = req_chan.payload;
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign merged_bank1   = {bank_ff[1][7:6], req.eeprom_data_in, bank_ff[1][4:0]};
   assign gun_x2         = req.sample_value + aio_pkg::GUN_X2_OFFSET;
   assign gun_addr_reset = aio_pkg::reg_reset_value(aio_pkg::ADDR_GUN_ADDR);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      bank_in      = bank_ff;
      bank_sel_in  = bank_sel_ff;
      gun_in       = gun_ff;
      gun_ptr_in   = gun_ptr_ff;
      steer_in     = steer_ff;
      steer_cnt_in = steer_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = req.address;
      wr_data      = req.write_data;
      rd_addr      = req.address;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               case (req.opcode)
                  aio_pkg::OP_READ: begin
                     if (req.address == aio_pkg::ADDR_EEPROM) begin
                        bank_in[1] = merged_bank1;
                        rsp_data_in.read_data = bank_sel_ff ? merged_bank1 : bank_ff[0];
                     end else if (req.address == aio_pkg::ADDR_STEER) begin
                        rsp_data_in.read_data = steer_ff[steer_cnt_ff];
                        steer_cnt_in = steer_cnt_ff + 3'd1;
                     end else begin
                        // response comes when the memory data is back
                        rsp_valid_in = 1'b0;
                        addr_in      = req.address;
                        state_in     = ST_RD;
                     end
                  end
                  aio_pkg::OP_WRITE: begin
                     wr_en = 1'b1;
                     if (req.address == aio_pkg::ADDR_BANK) begin
                        bank_sel_in = req.write_data[0];
                        if (req.write_data[0]) begin
                           rsp_data_in.eeprom_strobe  = 1'b1;
                           rsp_data_in.eeprom_line_b6 = req.write_data[6];
                           rsp_data_in.eeprom_line_b7 = req.write_data[7];
                           rsp_data_in.eeprom_line_b5 = req.write_data[5];
                           rsp_data_in.eeprom_line_b4 = req.write_data[4];
                        end
                     end else if (req.address == aio_pkg::ADDR_MCU_CMD) begin
                        if (req.write_data == aio_pkg::CMD_LATCH) begin
                           // gun address read runs beside the command write
                           rd_addr  = aio_pkg::ADDR_GUN_ADDR;
                           state_in = ST_PTR;
                        end else if (req.write_data == aio_pkg::CMD_COPY) begin
                           state_in = ST_CLR;
                        end
                     end
                  end
                  aio_pkg::OP_SAMPLE: begin
                     case (req.sample_slot)
                        aio_pkg::SLOT_SYS0: bank_in[0] = req.sample_value[7:0];
                        aio_pkg::SLOT_SYS1: bank_in[1] = req.sample_value[7:0];
                        aio_pkg::SLOT_LEVER1: begin
                           wr_en   = 1'b1;
                           wr_addr = aio_pkg::ADDR_LEVER1;
                           wr_data = req.sample_value[7:0];
                        end
                        aio_pkg::SLOT_LEVER2: begin
                           wr_en   = 1'b1;
                           wr_addr = aio_pkg::ADDR_LEVER2;
                           wr_data = req.sample_value[7:0];
                        end
                        aio_pkg::SLOT_GUN_Y1: begin
                           gun_in[0] = req.sample_value[7:0];
                           gun_in[1] = {5'd0, req.sample_value[10:8]};
                        end
                        aio_pkg::SLOT_GUN_X1: begin
                           gun_in[2] = req.sample_value[7:0];
                           gun_in[3] = {5'd0, req.sample_value[10:8]};
                        end
                        aio_pkg::SLOT_GUN_Y2: begin
                           gun_in[4] = req.sample_value[7:0];
                           gun_in[5] = {5'd0, req.sample_value[10:8]};
                        end
                        aio_pkg::SLOT_GUN_X2: begin
                           gun_in[6] = gun_x2[7:0];
                           gun_in[7] = {5'd0, gun_x2[10:8]};
                        end
                        aio_pkg::SLOT_ACQUIRED: gun_in[8] = {6'd0, req.sample_value[1:0]};
                        aio_pkg::SLOT_STEER:
                           steer_in[0] = req.sample_value[7:0] + aio_pkg::STEER_OFFSET;
                        aio_pkg::SLOT_ACCEL: steer_in[1] = req.sample_value[7:0];
                        aio_pkg::SLOT_BRAKE: steer_in[2] = req.sample_value[7:0];
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end
         end
         ST_RD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_data_in.read_data = written_ff[addr_ff] ? rd_q_ff
                                                        : aio_pkg::reg_reset_value(addr_ff);
            state_in = ST_IDLE;
         end
         ST_PTR: begin
            gun_ptr_in = written_ff[aio_pkg::ADDR_GUN_ADDR] ? rd_q_ff[3:0]
                                                             : gun_addr_reset[3:0];
            state_in   = ST_IDLE;
         end
         ST_CLR: begin
            wr_en    = 1'b1;
            wr_addr  = aio_pkg::ADDR_MCU_FLAG;
            wr_data  = 8'h00;
            state_in = ST_GUN;
         end
         ST_GUN: begin
            wr_en    = 1'b1;
            wr_addr  = aio_pkg::ADDR_GUN_DATA;
            wr_data  = gun_ff[gun_ptr_ff];
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         written_ff   <= '0;
         bank_ff      <= '{default: 8'hFF};
         bank_sel_ff  <= 1'b0;
         gun_ff       <= '{default: 8'h00};
         gun_ptr_ff   <= '0;
         steer_ff     <= '{default: 8'h00};
         steer_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         written_ff   <= written_in;
         bank_ff      <= bank_in;
         bank_sel_ff  <= bank_sel_in;
         gun_ff       <= gun_in;
         gun_ptr_ff   <= gun_ptr_in;
         steer_ff     <= steer_in;
         steer_cnt_ff <= steer_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // register memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         reg_mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= reg_mem[rd_addr];
   end

endmodule

[hdl/aio_checker.sv]
// ----------------------------------------------------------------------------
// aio_checker
// Port-level checks on the control I/O register block, bound to its top.
// ----------------------------------------------------------------------------
module aio_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input aio_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input aio_pkg::rsp_payload_type rsp_payload
);

   logic mem_read;

   assign mem_read = req_valid && req_ready && req_payload.opcode == aio_pkg::OP_READ
                     && req_payload.address != aio_pkg::ADDR_EEPROM
                     && req_payload.address != aio_pkg::ADDR_STEER;

   // no response left over after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("stalled response changed");

   // memory read blocks the next request, then shows its data
   a_mem_read: assert property (@(posedge clock) disable iff (reset)
      mem_read |=> !req_ready ##1 rsp_valid)
      else $error("memory read response timing");

   a_lines_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.eeprom_strobe |->
         !rsp_payload.eeprom_line_b6 && !rsp_payload.eeprom_line_b7 &&
         !rsp_payload.eeprom_line_b5 && !rsp_payload.eeprom_line_b4)
      else $error("eeprom lines driven without strobe");

   a_strobe_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.eeprom_strobe |-> rsp_payload.read_data == 8'h00)
      else $error("strobe response carries read data");

endmodule

bind arcade_control_io_registers aio_checker u_aio_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_payload (req_chan.payload),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the control I/O register block. A driver sends bus
// reads, bus writes and sample loads from a pending queue with random gaps.
// A monitor applies random back-pressure and checks every response, field by
// field, against a local model of the register file, bank, gun and steering
// state.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                     drain;
      aio_pkg::req_payload_type payload;
   } pending_req_type;

   logic clock;
   logic reset;

   aio_req_if req_if();
   aio_rsp_if rsp_if();

   arcade_control_io_registers u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #6 clock = ~clock;

   // local copy of the block state
   logic [7:0] reg_q   [aio_pkg::REG_DEPTH];
   logic [7:0] bank_q  [2];
   logic       bank_sel;
   logic [7:0] gun_q   [aio_pkg::GUN_DEPTH];
   logic [3:0] gun_ptr;
   logic [7:0] steer_q [aio_pkg::STEER_DEPTH];
   logic [2:0] steer_cnt;

   pending_req_type pending_q[$];
   aio_pkg::rsp_payload_type io_response_q[$];

   int  mismatch_count = 0;
   int  counted_reqs   = 0;
   logic drain_next    = 1'b0;
   int  req_gap  = 0;
   int  req_calm = 0;
   int  rsp_stall = 0;
   int  rsp_calm  = 0;

   task automatic reset_io_state();
      for (int a = 0; a < aio_pkg::REG_DEPTH; a++) begin
         if (a <= aio_pkg::ADDR_ZERO_HIGH || a == aio_pkg::ADDR_ZERO_ONE) begin
            reg_q[a] = 8'h00;
         end else begin
            reg_q[a] = 8'hFF;
         end
      end
      bank_q[0] = 8'hFF;
      bank_q[1] = 8'hFF;
      bank_sel  = 1'b0;
      for (int g = 0; g < aio_pkg::GUN_DEPTH; g++) gun_q[g] = 8'h00;
      gun_ptr = 4'd0;
      for (int s = 0; s < aio_pkg::STEER_DEPTH; s++) steer_q[s] = 8'h00;
      steer_cnt = 3'd0;
   endtask

   // 11-bit gun value split into low byte and upper three bits
   function automatic void pack_gun_value(input logic [3:0] base, input logic [10:0] v);
      logic [3:0] upper;
      upper = base + 4'd1;
      gun_q[base]  = v[7:0];
      gun_q[upper] = {5'b0, v[10:8]};
   endfunction

   function automatic aio_pkg::rsp_payload_type predict_io_response(
      input aio_pkg::req_payload_type rq);
      aio_pkg::rsp_payload_type rs;
      logic [10:0]              gun_x2;
      rs = '0;
      case (rq.opcode)
         aio_pkg::OP_READ: begin
            if (rq.address == aio_pkg::ADDR_EEPROM) begin
               bank_q[1][5] = rq.eeprom_data_in;
               rs.read_data = bank_q[bank_sel];
            end else if (rq.address == aio_pkg::ADDR_STEER) begin
               rs.read_data = steer_q[steer_cnt];
               steer_cnt = steer_cnt + 3'd1;
            end else begin
               rs.read_data = reg_q[rq.address];
            end
         end
         aio_pkg::OP_WRITE: begin
            reg_q[rq.address] = rq.write_data;
            if (rq.address == aio_pkg::ADDR_BANK) begin
               bank_sel = rq.write_data[0];
               if (bank_sel) begin
                  rs.eeprom_strobe  = 1'b1;
                  rs.eeprom_line_b6 = rq.write_data[6];
                  rs.eeprom_line_b7 = rq.write_data[7];
                  rs.eeprom_line_b5 = rq.write_data[5];
                  rs.eeprom_line_b4 = rq.write_data[4];
               end
            end else if (rq.address == aio_pkg::ADDR_MCU_CMD) begin
               if (rq.write_data == aio_pkg::CMD_LATCH) begin
                  gun_ptr = reg_q[aio_pkg::ADDR_GUN_ADDR][3:0];
               end else if (rq.write_data == aio_pkg::CMD_COPY) begin
                  reg_q[aio_pkg::ADDR_MCU_FLAG] = 8'h00;
                  reg_q[aio_pkg::ADDR_GUN_DATA] = gun_q[gun_ptr];
               end
            end
         end
         aio_pkg::OP_SAMPLE: begin
            case (rq.sample_slot)
               aio_pkg::SLOT_SYS0:     bank_q[0] = rq.sample_value[7:0];
               aio_pkg::SLOT_SYS1:     bank_q[1] = rq.sample_value[7:0];
               aio_pkg::SLOT_LEVER1:   reg_q[aio_pkg::ADDR_LEVER1] = rq.sample_value[7:0];
               aio_pkg::SLOT_LEVER2:   reg_q[aio_pkg::ADDR_LEVER2] = rq.sample_value[7:0];
               aio_pkg::SLOT_GUN_Y1:   pack_gun_value(4'd0, rq.sample_value);
               aio_pkg::SLOT_GUN_X1:   pack_gun_value(4'd2, rq.sample_value);
               aio_pkg::SLOT_GUN_Y2:   pack_gun_value(4'd4, rq.sample_value);
               aio_pkg::SLOT_GUN_X2: begin
                  gun_x2 = rq.sample_value + aio_pkg::GUN_X2_OFFSET;
                  pack_gun_value(4'd6, gun_x2);
               end
               aio_pkg::SLOT_ACQUIRED: gun_q[8] = {6'b0, rq.sample_value[1:0]};
               aio_pkg::SLOT_STEER:
                  steer_q[0] = rq.sample_value[7:0] + aio_pkg::STEER_OFFSET;
               aio_pkg::SLOT_ACCEL:    steer_q[1] = rq.sample_value[7:0];
               aio_pkg::SLOT_BRAKE:    steer_q[2] = rq.sample_value[7:0];
               default: ;
            endcase
         end
         default: ;
      endcase
      return rs;
   endfunction

   // mostly short gaps, a few long ones, and now and then a stretch of none
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(15, 50);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s expected %0h actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin : drive_req
      logic            send;
      pending_req_type head;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         send = req_if.valid && !req_if.ready;
         if (req_if.valid && req_if.ready) begin
            io_response_q.push_back(predict_io_response(req_if.payload));
            req_gap = pick_gap(req_calm);
         end
         if (!send) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_q.size() > 0 &&
                         (!pending_q[0].drain || io_response_q.size() == 0)) begin
               head = pending_q.pop_front();
               req_if.payload <= head.payload;
               send = 1'b1;
            end
         end
         req_if.valid <= send;
      end
   end

   // --------------------------------------------------------------- monitor
   always @(posedge clock) begin : watch_rsp
      aio_pkg::rsp_payload_type want;
      logic                     nxt;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (io_response_q.size() == 0) begin
               $error("response with no request waiting: %0h", rsp_if.payload);
               mismatch_count++;
            end else begin
               want = io_response_q.pop_front();
               check_field("read_data", want.read_data, rsp_if.payload.read_data);
               check_field("eeprom_strobe", 8'(want.eeprom_strobe),
                           8'(rsp_if.payload.eeprom_strobe));
               check_field("eeprom_line_b6", 8'(want.eeprom_line_b6),
                           8'(rsp_if.payload.eeprom_line_b6));
               check_field("eeprom_line_b7", 8'(want.eeprom_line_b7),
                           8'(rsp_if.payload.eeprom_line_b7));
               check_field("eeprom_line_b5", 8'(want.eeprom_line_b5),
                           8'(rsp_if.payload.eeprom_line_b5));
               check_field("eeprom_line_b4", 8'(want.eeprom_line_b4),
                           8'(rsp_if.payload.eeprom_line_b4));
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            nxt = 1'b0;
         end else begin
            nxt = 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_stall = pick_gap(rsp_calm);
         end
         rsp_if.ready <= nxt;
      end
   end

   // ------------------------------------------------------------- stimulus
   function automatic aio_pkg::req_payload_type any_req();
      aio_pkg::req_payload_type pl;
      pl.opcode         = aio_pkg::opcode_type'($urandom_range(0, 3));
      pl.address        = 6'($urandom);
      pl.write_data     = 8'($urandom);
      pl.sample_slot    = 4'($urandom);
      pl.sample_value   = 11'($urandom);
      pl.eeprom_data_in = 1'($urandom);
      return pl;
   endfunction

   function automatic logic [10:0] any_sample();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 11'h000;
      if (r == 1) return 11'h7FF;
      return 11'($urandom);
   endfunction

   task automatic push_item(input aio_pkg::req_payload_type pl);
      pending_req_type item;
      item.drain   = drain_next;
      item.payload = pl;
      drain_next   = 1'b0;
      pending_q.push_back(item);
      if (pl.opcode != aio_pkg::OP_NOP &&
          !(pl.opcode == aio_pkg::OP_SAMPLE && pl.sample_slot > aio_pkg::SLOT_BRAKE))
         counted_reqs++;
   endtask

   task automatic bus_read(input logic [5:0] addr);
      aio_pkg::req_payload_type pl;
      pl = any_req();
      pl.opcode  = aio_pkg::OP_READ;
      pl.address = addr;
      push_item(pl);
   endtask

   task automatic bus_write(input logic [5:0] addr, input logic [7:0] data);
      aio_pkg::req_payload_type pl;
      pl = any_req();
      pl.opcode     = aio_pkg::OP_WRITE;
      pl.address    = addr;
      pl.write_data = data;
      push_item(pl);
   endtask

   task automatic sample_load(input logic [3:0] slot, input logic [10:0] value);
      aio_pkg::req_payload_type pl;
      pl = any_req();
      pl.opcode       = aio_pkg::OP_SAMPLE;
      pl.sample_slot  = slot;
      pl.sample_value = value;
      push_item(pl);
   endtask

   task automatic status_byte_read(input logic ebit);
      aio_pkg::req_payload_type pl;
      pl = any_req();
      pl.opcode         = aio_pkg::OP_READ;
      pl.address        = aio_pkg::ADDR_EEPROM;
      pl.eeprom_data_in = ebit;
      push_item(pl);
   endtask

   initial begin : stimulus
      aio_pkg::req_payload_type pl;
      logic [5:0]               addr;
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      reset_io_state();

      // directed: reset values, bank select and eeprom lines
      bus_read(aio_pkg::ADDR_BANK);
      bus_read(aio_pkg::ADDR_ZERO_ONE);
      bus_read(aio_pkg::ADDR_LEVER1);
      status_byte_read(1'b1);
      bus_write(aio_pkg::ADDR_BANK, 8'hF1);
      bus_write(aio_pkg::ADDR_BANK, 8'h0E);
      bus_write(aio_pkg::ADDR_BANK, 8'h51);
      status_byte_read(1'b0);
      // gun x wrap after the offset, acquired flags, then the mcu copy
      sample_load(aio_pkg::SLOT_GUN_X2, 11'h7FF);
      sample_load(aio_pkg::SLOT_ACQUIRED, 11'h7FF);
      bus_write(aio_pkg::ADDR_GUN_ADDR, 8'hF6);
      bus_write(aio_pkg::ADDR_MCU_CMD, aio_pkg::CMD_LATCH);
      bus_write(aio_pkg::ADDR_MCU_CMD, aio_pkg::CMD_COPY);
      drain_next = 1'b1;
      bus_read(aio_pkg::ADDR_GUN_DATA);
      bus_read(aio_pkg::ADDR_MCU_FLAG);
      // steering offset wrap and counter
      sample_load(aio_pkg::SLOT_STEER, 11'h7FF);
      bus_read(aio_pkg::ADDR_STEER);
      bus_read(aio_pkg::ADDR_STEER);
      // writes to eeprom and steering, which their reads never return, and a stray mcu command
      bus_write(aio_pkg::ADDR_EEPROM, 8'hAA);
      bus_write(aio_pkg::ADDR_STEER, 8'h5A);
      bus_write(aio_pkg::ADDR_MCU_CMD, 8'h55);
      // ignored slot, no-op, then a write and read of the top address
      pl = any_req();
      pl.opcode      = aio_pkg::OP_SAMPLE;
      pl.sample_slot = 4'd15;
      push_item(pl);
      pl = any_req();
      pl.opcode = aio_pkg::OP_NOP;
      push_item(pl);
      bus_write(6'h3F, 8'h00);
      bus_read(6'h3F);

      counted_reqs = 0;
      drain_next   = 1'b1;
      while (counted_reqs < 400) begin
         if ($urandom_range(0, 39) == 0) drain_next = 1'b1;
         case ($urandom_range(0, 9))
            0, 1: push_item(any_req());
            2, 3: begin
               repeat ($urandom_range(1, 4))
                  sample_load(4'($urandom_range(aio_pkg::SLOT_GUN_Y1, aio_pkg::SLOT_ACQUIRED)),
                              any_sample());
               bus_write(aio_pkg::ADDR_GUN_ADDR, 8'($urandom));
               if ($urandom_range(0, 4) != 0)
                  bus_write(aio_pkg::ADDR_MCU_CMD, aio_pkg::CMD_LATCH);
               bus_write(aio_pkg::ADDR_MCU_CMD, aio_pkg::CMD_COPY);
               bus_read(aio_pkg::ADDR_GUN_DATA);
               bus_read(aio_pkg::ADDR_MCU_FLAG);
            end
            4: begin
               repeat ($urandom_range(1, 3))
                  sample_load(4'($urandom_range(aio_pkg::SLOT_STEER, aio_pkg::SLOT_BRAKE)),
                              any_sample());
               repeat ($urandom_range(1, 9)) bus_read(aio_pkg::ADDR_STEER);
            end
            5: begin
               bus_write(aio_pkg::ADDR_BANK, 8'($urandom));
               sample_load(4'($urandom_range(aio_pkg::SLOT_SYS0, aio_pkg::SLOT_SYS1)),
                           any_sample());
               repeat ($urandom_range(1, 3)) status_byte_read(1'($urandom));
            end
            6: begin
               if ($urandom_range(0, 1) == 0) begin
                  sample_load(aio_pkg::SLOT_LEVER1, any_sample());
                  bus_read(aio_pkg::ADDR_LEVER1);
               end else begin
                  sample_load(aio_pkg::SLOT_LEVER2, any_sample());
                  bus_read(aio_pkg::ADDR_LEVER2);
               end
            end
            7: begin
               addr = 6'($urandom);
               bus_write(addr, 8'($urandom));
               bus_read(addr);
            end
            8: begin
               // stray mcu command, then look at what the gun data register holds
               bus_write(aio_pkg::ADDR_MCU_CMD, 8'($urandom));
               bus_read(aio_pkg::ADDR_GUN_DATA);
            end
            default: bus_read(6'($urandom));
         endcase
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() > 0 || req_if.valid || io_response_q.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
